FILE: hdl/rpm_pkg.sv
// Shared types and constants of the RGBA pixel mixer.
// No dependencies; every other file of the block uses it.
package rpm_pkg;

  localparam int unsigned ChanW     = 16;
  localparam int unsigned ProdW     = 2 * ChanW;
  localparam int unsigned NumChan   = 4;
  localparam int unsigned NumStages = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [ChanW-1:0] FullScale = {ChanW{1'b1}};
  localparam logic [ChanW-1:0] HalfScale = {1'b0, {(ChanW-1){1'b1}}};

  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;
  localparam int unsigned ChAlpha = 3;

  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [1:0] {
    ModeBlend = 2'd0,
    ModeAdd   = 2'd1,
    ModeXfade = 2'd2
  } mix_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMixMode   = 1'd0,
    RegMixFactor = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    mix_mode_e mode;
    chan_t     factor;
  } cfg_t;

  typedef struct packed {
    logic [NumChan-1:0][ChanW-1:0] a;
    logic [NumChan-1:0][ChanW-1:0] b;
  } pix_pair_t;

  typedef struct packed {
    logic [NumChan-1:0][ChanW-1:0] c;
  } pix_out_t;

  typedef struct packed {
    logic ld_p;
    logic ld_q;
    logic ld_r;
  } mul_en_t;

  typedef struct packed {
    mul_en_t mul;
    logic    ld_out;
  } blend_en_t;

endpackage

FILE: hdl/rpm_if.sv
// Valid/ready channel interfaces for pixel pairs in and mixed pixels out.
// Depends on rpm_pkg for the channel type.
interface rpm_in_if;
  logic            valid;
  logic            ready;
  rpm_pkg::chan_t  a_red;
  rpm_pkg::chan_t  a_green;
  rpm_pkg::chan_t  a_blue;
  rpm_pkg::chan_t  a_alpha;
  rpm_pkg::chan_t  b_red;
  rpm_pkg::chan_t  b_green;
  rpm_pkg::chan_t  b_blue;
  rpm_pkg::chan_t  b_alpha;

  modport source (
    output valid, a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha,
    input  ready
  );
  modport sink (
    input  valid, a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha,
    output ready
  );
endinterface

interface rpm_out_if;
  logic            valid;
  logic            ready;
  rpm_pkg::chan_t  out_red;
  rpm_pkg::chan_t  out_green;
  rpm_pkg::chan_t  out_blue;
  rpm_pkg::chan_t  out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

FILE: hdl/rgba_pixel_mixer_top.sv
// RGBA pixel mixer: blend over, additive and crossfade of two 0.16 pixels.
// Throughput: one beat per cycle while the output is ready; a full stage stalls only when the one after it stalls too.
// Reset clears every stage valid bit and sets mode to crossfade, factor to zero.
// Depends on rpm_pkg, rpm_if, rpm_weight, rpm_blend and rpm_fxmul.
module rgba_pixel_mixer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpm_in_if.sink                         in_pix,
  rpm_out_if.source                      out_pix,
  input  logic                           cfg_we_i,
  input  logic [rpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rpm_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import rpm_pkg::*;

  cfg_t                 cfg_q;
  logic [NumStages-1:0] v_q, rdy;
  pix_pair_t            pix_in, pix_mid;
  pix_out_t             pix_out;
  chan_t                k, t;
  mul_en_t              wt_en;
  blend_en_t            bl_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeXfade;
      cfg_q.factor <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegMixMode:   cfg_q.mode   <= mix_mode_e'(cfg_wdata_i[1:0]);
        RegMixFactor: cfg_q.factor <= cfg_wdata_i[ChanW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || out_pix.ready;
    for (int i = NumStages-2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_pix.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_pix.ready = rdy[0];

  assign pix_in.a[ChRed]   = in_pix.a_red;
  assign pix_in.a[ChGreen] = in_pix.a_green;
  assign pix_in.a[ChBlue]  = in_pix.a_blue;
  assign pix_in.a[ChAlpha] = in_pix.a_alpha;
  assign pix_in.b[ChRed]   = in_pix.b_red;
  assign pix_in.b[ChGreen] = in_pix.b_green;
  assign pix_in.b[ChBlue]  = in_pix.b_blue;
  assign pix_in.b[ChAlpha] = in_pix.b_alpha;

  assign wt_en.ld_p     = rdy[0];
  assign wt_en.ld_q     = rdy[1];
  assign wt_en.ld_r     = rdy[2];
  assign bl_en.mul.ld_p = rdy[3];
  assign bl_en.mul.ld_q = rdy[4];
  assign bl_en.mul.ld_r = rdy[5];
  assign bl_en.ld_out   = rdy[6];

  rpm_weight u_weight (
    .clk_i (clk_i),
    .en_i  (wt_en),
    .cfg_i (cfg_q),
    .pix_i (pix_in),
    .pix_o (pix_mid),
    .k_o   (k),
    .t_o   (t)
  );

  rpm_blend u_blend (
    .clk_i (clk_i),
    .en_i  (bl_en),
    .cfg_i (cfg_q),
    .pix_i (pix_mid),
    .k_i   (k),
    .t_i   (t),
    .pix_o (pix_out)
  );

  assign out_pix.valid     = v_q[NumStages-1];
  assign out_pix.out_red   = pix_out.c[ChRed];
  assign out_pix.out_green = pix_out.c[ChGreen];
  assign out_pix.out_blue  = pix_out.c[ChBlue];
  assign out_pix.out_alpha = pix_out.c[ChAlpha];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_pix.ready |-> (&v_q) && !out_pix.ready)
    else $error("input stalled with a free stage");

  a_accept_enters_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pix.valid && in_pix.ready |=> v_q[0])
    else $error("accepted beat missing from first stage");

  a_out_from_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_pix.valid) |-> $past(v_q[NumStages-2]))
    else $error("output beat without a beat behind it");

endmodule

FILE: hdl/rpm_fxmul.sv
// Three-stage 0.16 fixed point multiply, rounded: floor((x*y + half) / full).
// Division by full scale uses a reciprocal estimate and one correction step.
// Depends on rpm_pkg.
module rpm_fxmul (
  input  logic              clk_i,
  input  rpm_pkg::mul_en_t  en_i,
  input  rpm_pkg::chan_t    x_i,
  input  rpm_pkg::chan_t    y_i,
  output rpm_pkg::chan_t    q_o
);
  import rpm_pkg::*;

  logic [ProdW-1:0] p_d, p_q, p2_q, est_sum, base, rem;
  chan_t            q0_d, q0_q, q_d, q_q;

  assign p_d = ProdW'(x_i) * ProdW'(y_i) + ProdW'(HalfScale);

  assign est_sum = p_q + ProdW'(p_q[ProdW-1:ChanW]);
  assign q0_d    = est_sum[ProdW-1:ChanW];

  assign base = {q0_q, {ChanW{1'b0}}} - ProdW'(q0_q);
  assign rem  = p2_q - base;
  assign q_d  = q0_q + ChanW'(rem >= ProdW'(FullScale));

  always_ff @(posedge clk_i) begin
    if (en_i.ld_p) begin
      p_q <= p_d;
    end
    if (en_i.ld_q) begin
      p2_q <= p_q;
      q0_q <= q0_d;
    end
    if (en_i.ld_r) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

FILE: hdl/rpm_weight.sv
// Front stages: overlay weight k and the blend alpha term, pixel pair delayed alongside.
// Depends on rpm_pkg and rpm_fxmul.
module rpm_weight (
  input  logic               clk_i,
  input  rpm_pkg::mul_en_t   en_i,
  input  rpm_pkg::cfg_t      cfg_i,
  input  rpm_pkg::pix_pair_t pix_i,
  output rpm_pkg::pix_pair_t pix_o,
  output rpm_pkg::chan_t     k_o,
  output rpm_pkg::chan_t     t_o
);
  import rpm_pkg::*;

  pix_pair_t pix_p_q, pix_q_q, pix_r_q;
  chan_t     inv_a;

  assign inv_a = FullScale - pix_i.a[ChAlpha];

  rpm_fxmul u_mul_k (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (pix_i.b[ChAlpha]),
    .y_i   (cfg_i.factor),
    .q_o   (k_o)
  );

  rpm_fxmul u_mul_t (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (pix_i.b[ChAlpha]),
    .y_i   (inv_a),
    .q_o   (t_o)
  );

  always_ff @(posedge clk_i) begin
    if (en_i.ld_p) begin
      pix_p_q <= pix_i;
    end
    if (en_i.ld_q) begin
      pix_q_q <= pix_p_q;
    end
    if (en_i.ld_r) begin
      pix_r_q <= pix_q_q;
    end
  end

  assign pix_o = pix_r_q;

endmodule

FILE: hdl/rpm_blend.sv
// Back stages: per-channel weighted products of A and B (of t for blend-mode alpha), then saturating sum.
// Depends on rpm_pkg and rpm_fxmul.
module rpm_blend (
  input  logic               clk_i,
  input  rpm_pkg::blend_en_t en_i,
  input  rpm_pkg::cfg_t      cfg_i,
  input  rpm_pkg::pix_pair_t pix_i,
  input  rpm_pkg::chan_t     k_i,
  input  rpm_pkg::chan_t     t_i,
  output rpm_pkg::pix_out_t  pix_o
);
  import rpm_pkg::*;

  chan_t    wa [NumChan];
  chan_t    xb [NumChan];
  chan_t    wb [NumChan];
  chan_t    qa [NumChan];
  chan_t    qb [NumChan];
  pix_out_t out_d, out_q;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      wa[i] = FullScale;
      xb[i] = pix_i.b[i];
      wb[i] = '0;
    end
    unique case (cfg_i.mode)
      ModeBlend: begin
        for (int i = 0; i < ChAlpha; i++) begin
          wa[i] = FullScale - k_i;
          wb[i] = k_i;
        end
        xb[ChAlpha] = t_i;
        wb[ChAlpha] = cfg_i.factor;
      end
      ModeAdd: begin
        for (int i = 0; i < ChAlpha; i++) begin
          wb[i] = k_i;
        end
      end
      ModeXfade: begin
        for (int i = 0; i < NumChan; i++) begin
          wa[i] = FullScale - cfg_i.factor;
          wb[i] = cfg_i.factor;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < NumChan; g++) begin : g_chan
    logic [ChanW:0] sum;

    rpm_fxmul u_mul_a (
      .clk_i (clk_i),
      .en_i  (en_i.mul),
      .x_i   (pix_i.a[g]),
      .y_i   (wa[g]),
      .q_o   (qa[g])
    );

    rpm_fxmul u_mul_b (
      .clk_i (clk_i),
      .en_i  (en_i.mul),
      .x_i   (xb[g]),
      .y_i   (wb[g]),
      .q_o   (qb[g])
    );

    assign sum        = (ChanW+1)'(qa[g]) + (ChanW+1)'(qb[g]);
    assign out_d.c[g] = sum[ChanW] ? FullScale : sum[ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      out_q <= out_d;
    end
  end

  assign pix_o = out_q;

endmodule
